### hdl/unsigned_restoring_divider_64_core_macros.svh
// Assertion macros shared by the divider checker.
`ifndef UNSIGNED_RESTORING_DIVIDER_64_CORE_MACROS_SVH
`define UNSIGNED_RESTORING_DIVIDER_64_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define UDIV64_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define UDIV64_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define UDIV64_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/udiv64_pkg.sv
// Package with the divider stage type, sizes and the one-bit restoring step.
package udiv64_pkg;

  localparam int DataW    = 64;
  localparam int NumSteps = 64;

  // Work carried from stage to stage: partial remainder in the upper half of acc,
  // unused dividend bits and finished quotient bits sharing the lower half.
  typedef struct packed {
    logic [2*DataW-1:0] acc;
    logic [DataW-1:0]   den;
    logic               dbz;
  } stage_t;

  // One restoring step: bring down the next dividend bit, subtract when it fits.
  // A zero divisor never subtracts, so the dividend ends up as the remainder.
  function automatic stage_t div_step(stage_t s);
    logic [DataW:0] t;
    logic [DataW:0] tn;
    logic           take;
    stage_t         r;
    t    = {s.acc[2*DataW-1:DataW], s.acc[DataW-1]};
    take = !s.dbz && (t >= {1'b0, s.den});
    tn   = take ? (t - {1'b0, s.den}) : t;
    r     = s;
    r.acc = {tn[DataW-1:0], s.acc[DataW-2:0], take};
    return r;
  endfunction

endpackage

### hdl/unsigned_restoring_divider_64_core.sv
// Top level of the pipelined 64-bit unsigned restoring divider.
//
// Requests carry dividend and divisor on a valid/ready channel; results carry
// quotient, remainder and divide_by_zero on a second valid/ready channel.
// A zero divisor gives quotient 0, remainder equal to the dividend and
// divide_by_zero set.
// The datapath is 64 register stages, each resolving one quotient bit with a
// 65-bit compare and subtract. The first stage loads at the accepting edge, and
// the request then passes through the stage registers in order; out_valid rises
// when it reaches the last one.
// One request per cycle is accepted and one result per cycle is delivered in
// steady state when the output is not stalled.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes; one more request is still taken into a skid register, and
// in_ready drops only while that register is occupied.
// Synchronous reset clears every valid bit, including the skid valid flag;
// payloads in flight are dropped.
module unsigned_restoring_divider_64_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [udiv64_pkg::DataW-1:0] dividend,
  input  logic [udiv64_pkg::DataW-1:0] divisor,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [udiv64_pkg::DataW-1:0] quotient,
  output logic [udiv64_pkg::DataW-1:0] remainder,
  output logic                         divide_by_zero
);

  logic [udiv64_pkg::NumSteps:0] stg_valid;
  udiv64_pkg::stage_t            stg_data [udiv64_pkg::NumSteps+1];
  logic                          en;

  // The pipeline advances unless a finished result is waiting to be taken.
  assign en = !stg_valid[udiv64_pkg::NumSteps] || out_ready;

  // Input skid feeds the first stage.
  udiv64_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .dividend (dividend),
    .divisor  (divisor),
    .en       (en),
    .valid    (stg_valid[0]),
    .data     (stg_data[0])
  );

  // One stage per quotient bit, most significant first.
  for (genvar i = 0; i < udiv64_pkg::NumSteps; i++) begin : g_stage
    udiv64_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (stg_valid[i]),
      .in_data  (stg_data[i]),
      .valid    (stg_valid[i+1]),
      .data     (stg_data[i+1])
    );
  end

  // The last stage register doubles as the output register.
  assign out_valid      = stg_valid[udiv64_pkg::NumSteps];
  assign quotient       = stg_data[udiv64_pkg::NumSteps].acc[udiv64_pkg::DataW-1:0];
  assign remainder      = stg_data[udiv64_pkg::NumSteps].acc[2*udiv64_pkg::DataW-1:
                                                             udiv64_pkg::DataW];
  assign divide_by_zero = stg_data[udiv64_pkg::NumSteps].dbz;

endmodule

### hdl/udiv64_skid.sv
// Input skid stage that holds one request while the pipeline is stalled.
module udiv64_skid (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [udiv64_pkg::DataW-1:0]        dividend,
  input  logic [udiv64_pkg::DataW-1:0]        divisor,
  input  logic                                en,
  output logic                                valid,
  output udiv64_pkg::stage_t                  data
);

  logic               skid_valid;
  udiv64_pkg::stage_t skid_data;
  udiv64_pkg::stage_t fresh;

  // Build the first stage word from the incoming request.
  always_comb begin
    fresh.acc = {{udiv64_pkg::DataW{1'b0}}, dividend};
    fresh.den = divisor;
    fresh.dbz = (divisor == '0);
  end

  assign in_ready = !skid_valid;
  assign valid    = skid_valid || in_valid;
  assign data     = skid_valid ? skid_data : fresh;

  // The held request drains as soon as the pipeline moves.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Capture the payload when a request arrives during a stall.
  always_ff @(posedge clk) begin
    if (!en && in_valid && !skid_valid) begin
      skid_data <= fresh;
    end
  end

endmodule

### hdl/udiv64_stage.sv
// One pipeline stage of the divider: a single compare-subtract and its registers.
module udiv64_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  udiv64_pkg::stage_t in_data,
  output logic               valid,
  output udiv64_pkg::stage_t data
);

  // Valid bit moves with the data whenever the pipeline advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  // Payload register holds one step's result.
  always_ff @(posedge clk) begin
    if (en) begin
      data <= udiv64_pkg::div_step(in_data);
    end
  end

endmodule

### hdl/udiv64_checker.sv
// Port-level checker for the divider, bound to the top level.
`include "unsigned_restoring_divider_64_core_macros.svh"

module udiv64_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [udiv64_pkg::DataW-1:0] dividend,
  input logic [udiv64_pkg::DataW-1:0] divisor,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [udiv64_pkg::DataW-1:0] quotient,
  input logic [udiv64_pkg::DataW-1:0] remainder,
  input logic                         divide_by_zero
);

  // A stalled result keeps its payload.
  `UDIV64_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(quotient) && $stable(remainder) && $stable(divide_by_zero), "stalled result changed")

  // A zero divisor always reports a zero quotient.
  `UDIV64_ASSERT_IMP(a_dbz_quo, out_valid && divide_by_zero, quotient == '0, "nonzero quotient on divide by zero")

  // Back-pressure on requests only comes from a waiting result.
  `UDIV64_ASSERT_IMP(a_ready_stall, !in_ready, out_valid, "request stalled without a waiting result")

  // Reset empties the pipeline.
  `UDIV64_ASSERT_RST(a_reset_empty, rst, !out_valid && in_ready, "pipeline not empty after reset")

endmodule

bind unsigned_restoring_divider_64_core udiv64_checker u_udiv64_checker (.*);
